// ----- rtl/fbd_pkg.sv -----
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types, constants and helper functions of the firmware byte
// descrambler: group reorder, nibble fix, word keys and byte permutations.
// ----------------------------------------------------------------------------
package fbd_pkg;

  // configuration register indexes
  localparam int unsigned   CFG_IDX_W = 2;
  localparam logic [1:0]    REG_FIRST = 2'd0;
  localparam logic [1:0]    REG_LAST  = 2'd1;
  localparam int unsigned   CFG_W     = 16;

  // reset values of the packet window
  localparam logic [15:0]   FIRST_RESET = 16'd10;
  localparam logic [15:0]   LAST_RESET  = 16'd100;

  // default geometry
  localparam int unsigned   PACKET_BYTES_DEF = 52;
  localparam int unsigned   KEY_WORDS_DEF    = 13;
  localparam int unsigned   Q_DEPTH          = 4;

  // first pass group geometry
  localparam int unsigned   GROUP_BYTES = 10;
  localparam int unsigned   GRP_W       = 4;

  // word key table
  localparam int unsigned   KEY_ENTRIES = 13;
  localparam int unsigned   KEY_SEL_W   = 4;
  localparam logic [31:0]   WORD_KEY [KEY_ENTRIES] = '{
    32'h55aa55aa, 32'haa55aa55, 32'h000000ff, 32'h0000ff00, 32'h00ff0000,
    32'hff000000, 32'h00000000, 32'hffffffff, 32'h0f0f0f0f, 32'hf0f0f0f0,
    32'haaaaaaaa, 32'h55555555, 32'h00000000
  };

  // byte permutation rows, selected by packet index bits [2:0]
  localparam logic [1:0]    BYTE_PERM [8][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd1, 2'd2, 2'd0, 2'd3},
    '{2'd2, 2'd3, 2'd1, 2'd0}, '{2'd0, 2'd2, 2'd1, 2'd3}
  };

  // one byte between the first and second pass
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } fbd_item_t;

  // packet window registers
  typedef struct packed {
    logic [15:0] first;
    logic [15:0] last;
  } fbd_cfg_t;

  // source slot of output position p in a group holding n bytes
  function automatic logic [GRP_W-1:0] group_src(input logic [GRP_W-1:0] p,
                                                 input logic [GRP_W-1:0] n);
    logic [GRP_W-1:0] q;
    // pair swap applies only to complete pairs
    q = ((p | 4'd1) < n) ? (p ^ 4'd1) : p;
    // half swaps of bytes 0 and 4, and of bytes 5 and 9, only on complete halves
    if (n >= 4'd5 && q == 4'd0) begin
      q = 4'd4;
    end else if (n >= 4'd5 && q == 4'd4) begin
      q = 4'd0;
    end else if (n >= 4'd10 && q == 4'd5) begin
      q = 4'd9;
    end else if (n >= 4'd10 && q == 4'd9) begin
      q = 4'd5;
    end
    return q;
  endfunction

  // ((x - 7) & 0xf) << 4 | x >> 4
  function automatic logic [7:0] nibble_fix(input logic [7:0] x);
    logic [3:0] lo;
    lo = x[3:0] - 4'd7;
    return {lo, x[7:4]};
  endfunction

endpackage

// ----- rtl/fbd_front.sv -----
// ----------------------------------------------------------------------------
// fbd_front
// First pass: collects 10-byte groups into two alternating banks and drains
// a full bank in reordered form with the nibble fix applied.
// ----------------------------------------------------------------------------
module fbd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] in_byte
  input  logic              in_tlast,
  output logic              q_valid,
  input  logic              q_ready,
  output fbd_pkg::fbd_item_t q_item
);
  import fbd_pkg::*;

  logic [7:0]       bank_r [2][GROUP_BYTES];
  logic [GRP_W-1:0] bank_n_r [2];
  logic             bank_last_r [2];
  logic [1:0]       bank_full_r;
  logic             wb_r;
  logic             rb_r;
  logic [GRP_W-1:0] fill_r;
  logic [GRP_W-1:0] ptr_r;

  logic             in_acc;
  logic             group_end;
  logic             q_acc;
  logic             drain_end;
  logic [GRP_W-1:0] rd_n;
  logic [GRP_W-1:0] src;

  // fill side
  assign in_tready = ~bank_full_r[wb_r];
  assign in_acc    = in_tvalid & in_tready;
  assign group_end = (fill_r == GRP_W'(GROUP_BYTES - 1)) | in_tlast;

  // drain side
  assign rd_n        = bank_n_r[rb_r];
  assign src         = group_src(ptr_r, rd_n);
  assign drain_end   = (ptr_r == rd_n - 4'd1);
  assign q_valid     = bank_full_r[rb_r];
  assign q_acc       = q_valid & q_ready;
  assign q_item.data = nibble_fix(bank_r[rb_r][src]);
  assign q_item.last = bank_last_r[rb_r] & drain_end;

  // bank payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bank_r[wb_r][fill_r] <= in_tdata;
      if (group_end) begin
        bank_n_r[wb_r]    <= fill_r + 4'd1;
        bank_last_r[wb_r] <= in_tlast;
      end
    end
  end

  // bank ownership and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_full_r <= '0;
      wb_r        <= 1'b0;
      rb_r        <= 1'b0;
      fill_r      <= '0;
      ptr_r       <= '0;
    end else begin
      if (in_acc) begin
        if (group_end) begin
          bank_full_r[wb_r] <= 1'b1;
          wb_r              <= ~wb_r;
          fill_r            <= '0;
        end else begin
          fill_r <= fill_r + 4'd1;
        end
      end
      if (q_acc) begin
        if (drain_end) begin
          bank_full_r[rb_r] <= 1'b0;
          rb_r              <= ~rb_r;
          ptr_r             <= '0;
        end else begin
          ptr_r <= ptr_r + 4'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/fbd_fifo.sv -----
// ----------------------------------------------------------------------------
// fbd_fifo
// Short queue of first-pass bytes between the front and the back.
// ----------------------------------------------------------------------------
module fbd_fifo #(
  parameter int unsigned DEPTH = fbd_pkg::Q_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fbd_pkg::fbd_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fbd_pkg::fbd_item_t pop_item
);
  import fbd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fbd_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rp_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fbd_back.sv -----
// ----------------------------------------------------------------------------
// fbd_back
// Second pass: assembles words, applies key and byte permutation inside the
// packet window and plays closed words out of two alternating slots.
// ----------------------------------------------------------------------------
module fbd_back #(
  parameter int unsigned PACKET_BYTES = fbd_pkg::PACKET_BYTES_DEF,
  parameter int unsigned KEY_WORDS    = fbd_pkg::KEY_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  fbd_pkg::fbd_item_t q_item,
  input  fbd_pkg::fbd_cfg_t  cfg,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [7:0] out_byte
  output logic               out_tlast
);
  import fbd_pkg::*;

  localparam int unsigned OFF_W = $clog2(PACKET_BYTES);
  localparam int unsigned KW_W  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

  logic [7:0]           wbuf_r [4];
  logic [1:0]           fill_r;
  logic [OFF_W-1:0]     off_r;
  logic [15:0]          pidx_r;
  logic [KW_W-1:0]      kw_r;
  logic [KEY_SEL_W-1:0] ks_r;
  logic [7:0]           slot_data_r [2][4];
  logic [1:0]           slot_cnt_r [2];
  logic                 slot_last_r [2];
  logic [1:0]           slot_full_r;
  logic                 ws_r;
  logic                 rs_r;
  logic [1:0]           ep_r;

  logic                 take;
  logic                 active;
  logic                 word_done;
  logic                 pkt_end;
  logic                 close;
  logic [31:0]          key;
  logic [7:0]           cw [4];
  logic [7:0]           kb [4];
  logic [7:0]           scr [4];
  logic [7:0]           wr_bytes [4];
  logic [1:0]           sel [4];
  logic                 out_acc;
  logic                 slot_end;

  assign q_ready   = ~slot_full_r[ws_r];
  assign take      = q_valid & q_ready;
  assign active    = (pidx_r >= cfg.first) & (pidx_r <= cfg.last);
  assign word_done = (fill_r == 2'd3);
  assign pkt_end   = (off_r == OFF_W'(PACKET_BYTES - 1));
  assign close     = word_done | pkt_end | q_item.last;
  assign key       = WORD_KEY[ks_r];

  // current word with the incoming byte in place, then key and permutation
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cw[k]  = (fill_r == 2'(k)) ? q_item.data : wbuf_r[k];
      kb[k]  = key[8*k +: 8];
      sel[k] = BYTE_PERM[pidx_r[2:0]][k];
    end
    for (int k = 0; k < 4; k++) begin
      scr[k]      = cw[sel[k]] ^ kb[sel[k]];
      wr_bytes[k] = (word_done && active) ? scr[k] : cw[k];
    end
  end

  // result side
  assign out_tvalid = slot_full_r[rs_r];
  assign out_tdata  = slot_data_r[rs_r][ep_r];
  assign slot_end   = (ep_r == slot_cnt_r[rs_r]);
  assign out_tlast  = slot_last_r[rs_r] & slot_end;
  assign out_acc    = out_tvalid & out_tready;

  // word buffer and slot payload
  always_ff @(posedge clk) begin
    if (take) begin
      wbuf_r[fill_r] <= q_item.data;
      if (close) begin
        for (int k = 0; k < 4; k++) begin
          slot_data_r[ws_r][k] <= wr_bytes[k];
        end
        slot_cnt_r[ws_r]  <= fill_r;
        slot_last_r[ws_r] <= q_item.last;
      end
    end
  end

  // word, packet and key counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      off_r  <= '0;
      pidx_r <= '0;
      kw_r   <= '0;
      ks_r   <= '0;
    end else if (take) begin
      if (q_item.last) begin
        fill_r <= '0;
        off_r  <= '0;
        pidx_r <= '0;
        kw_r   <= '0;
        ks_r   <= '0;
      end else begin
        fill_r <= close ? 2'd0 : fill_r + 2'd1;
        if (pkt_end) begin
          off_r <= '0;
          kw_r  <= '0;
          ks_r  <= '0;
          if (pidx_r != 16'hffff) begin
            pidx_r <= pidx_r + 16'd1;
          end
        end else begin
          off_r <= off_r + 1'b1;
          if (word_done) begin
            if (kw_r == KW_W'(KEY_WORDS - 1)) begin
              kw_r <= '0;
              ks_r <= '0;
            end else begin
              kw_r <= kw_r + 1'b1;
              ks_r <= (ks_r == KEY_SEL_W'(KEY_ENTRIES - 1)) ? '0 : ks_r + 1'b1;
            end
          end
        end
      end
    end
  end

  // slot ownership and playout pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_full_r <= '0;
      ws_r        <= 1'b0;
      rs_r        <= 1'b0;
      ep_r        <= '0;
    end else begin
      if (take && close) begin
        slot_full_r[ws_r] <= 1'b1;
        ws_r              <= ~ws_r;
      end
      if (out_acc) begin
        if (slot_end) begin
          slot_full_r[rs_r] <= 1'b0;
          rs_r              <= ~rs_r;
          ep_r              <= '0;
        end else begin
          ep_r <= ep_r + 2'd1;
        end
      end
    end
  end

endmodule

// ----- rtl/firmware_byte_descrambler.sv -----
// ----------------------------------------------------------------------------
// firmware_byte_descrambler
// Two-pass firmware byte descrambler: group reorder with nibble fix, then
// keyed word XOR and byte permutation on packets inside a configured window.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata           | tuser | tlast
//  in_*      | slave     | [7:0] in_byte   | -     | in_last
//  out_*     | master    | [7:0] out_byte  | -     | out_last
//  cfg_*     | write     | cfg_wdata[15:0] | -     | -
//
//  sustained one byte per clock in and out; a byte leaves when its 10-byte
//  group (or the stream end) is in and then its 4-byte word is complete
//  two group banks in the front and two word slots in the back let filling
//  and draining overlap; the input stalls when the output is held, and also
//  when a short final group lands while the other bank is still draining
//  reset clears all control state; the window registers reset to 10 and 100
//  tready on either side depends only on registered state
module firmware_byte_descrambler #(
  parameter int unsigned PACKET_BYTES = fbd_pkg::PACKET_BYTES_DEF,
  parameter int unsigned KEY_WORDS    = fbd_pkg::KEY_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] in_byte
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,
  input  logic                          cfg_wr_en,
  input  logic [fbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbd_pkg::CFG_W-1:0]     cfg_wdata
);
  import fbd_pkg::*;

  fbd_cfg_t  cfg_r;
  fbd_item_t f_item;
  fbd_item_t b_item;
  logic      f_valid;
  logic      f_ready;
  logic      b_valid;
  logic      b_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first <= FIRST_RESET;
      cfg_r.last  <= LAST_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FIRST: cfg_r.first <= cfg_wdata;
        REG_LAST:  cfg_r.last  <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // first pass
  fbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_item    (f_item)
  );

  // queue between the passes
  fbd_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  // second pass
  fbd_back #(
    .PACKET_BYTES (PACKET_BYTES),
    .KEY_WORDS    (KEY_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_item     (b_item),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // queue is never full and empty at once
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(!f_ready && !b_valid))
    else $error("queue reports full and empty together");

  // nothing is offered right after reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // both group banks are free right after reset
  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // a write to the lower window bound lands in the register
  a_cfg_first: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en && (cfg_index == REG_FIRST) |=> cfg_r.first == $past(cfg_wdata))
    else $error("lower window bound not written");

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the firmware byte descrambler. A directed table and
// random byte streams drive the input channel under several packet windows.
// A predictor mirrors the group reorder, nibble fix, keyed word XOR and byte
// permutation, and every output transaction is compared in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import fbd_pkg::*;

  localparam int unsigned PKT_BYTES    = 52;
  localparam int unsigned KEY_N        = 13;
  localparam int unsigned GROUP_N      = 10;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_WAIT     = 5000;
  localparam int unsigned HOLD_CYCLES  = 400;

  // indexes beyond the two window registers, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // per-word xor keys and output lane selection per packet index mod 8
  localparam logic [31:0] WORD_XOR [KEY_N] = '{
    32'h55aa55aa, 32'haa55aa55, 32'h000000ff, 32'h0000ff00, 32'h00ff0000,
    32'hff000000, 32'h00000000, 32'hffffffff, 32'h0f0f0f0f, 32'hf0f0f0f0,
    32'haaaaaaaa, 32'h55555555, 32'h00000000
  };
  localparam logic [1:0] LANE_SEL [8][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd2, 2'd3, 2'd0},
    '{2'd2, 2'd1, 2'd3, 2'd0}, '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd3, 2'd1, 2'd0, 2'd2}, '{2'd1, 2'd2, 2'd0, 2'd3},
    '{2'd2, 2'd3, 2'd1, 2'd0}, '{2'd0, 2'd2, 2'd1, 2'd3}
  };

  // directed row: input byte, last flag, and a typed-in result where obvious
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] want;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 25;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // single-byte streams: only the nibble fix applies
    '{8'h00, 1'b1, 1'b1, 8'h90}, '{8'hff, 1'b1, 1'b1, 8'h8f},
    '{8'h07, 1'b1, 1'b1, 8'h00}, '{8'h80, 1'b1, 1'b1, 8'h98},
    '{8'h17, 1'b1, 1'b1, 8'h01},
    // three bytes: one pair swapped, odd byte left alone
    '{8'h12, 1'b0, 1'b0, 8'h00}, '{8'h34, 1'b0, 1'b0, 8'h00},
    '{8'h56, 1'b1, 1'b0, 8'h00},
    // five bytes: complete first half, second half missing
    '{8'ha1, 1'b0, 1'b0, 8'h00}, '{8'hb2, 1'b0, 1'b0, 8'h00},
    '{8'hc3, 1'b0, 1'b0, 8'h00}, '{8'hd4, 1'b0, 1'b0, 8'h00},
    '{8'he5, 1'b1, 1'b0, 8'h00},
    // full group followed by a two-byte tail
    '{8'h01, 1'b0, 1'b0, 8'h00}, '{8'h23, 1'b0, 1'b0, 8'h00},
    '{8'h45, 1'b0, 1'b0, 8'h00}, '{8'h67, 1'b0, 1'b0, 8'h00},
    '{8'h89, 1'b0, 1'b0, 8'h00}, '{8'hab, 1'b0, 1'b0, 8'h00},
    '{8'hcd, 1'b0, 1'b0, 8'h00}, '{8'hef, 1'b0, 1'b0, 8'h00},
    '{8'hfe, 1'b0, 1'b0, 8'h00}, '{8'hdc, 1'b0, 1'b0, 8'h00},
    '{8'hba, 1'b0, 1'b0, 8'h00}, '{8'h98, 1'b1, 1'b0, 8'h00}
  };

  // dut ports, known from time zero
  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = 8'h00;  // [7:0] in_byte
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;           // [7:0] out_byte
  logic                 out_tlast;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_FIRST;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  // predictor state
  logic [7:0]  grp_mem [GROUP_N];
  int unsigned grp_cnt;
  logic [7:0]  wrd_mem [4];
  int unsigned wrd_cnt;
  int unsigned pkt_off;
  logic [15:0] pkt_idx;
  logic [15:0] win_first;
  logic [15:0] win_last;

  // bytes produced by one input transaction, and all bytes still owed
  fbd_item_t   step_out [$];
  fbd_item_t   plain_bytes_q [$];

  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  bit          tx_quiet     = 1'b0;

  firmware_byte_descrambler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    fbd_item_t item;
    item.data = b;
    item.last = 1'b0;
    step_out.push_back(item);
  endtask

  // whatever sits in the word buffer leaves unchanged
  task automatic flush_word();
    for (int k = 0; k < wrd_cnt; k++) begin
      queue_byte(wrd_mem[k]);
    end
    wrd_cnt = 0;
  endtask

  // predicted output bytes for one accepted input byte, into step_out
  task automatic descramble_step(input logic [7:0] b, input logic l);
    logic [7:0]  g [GROUP_N];
    logic [7:0]  t;
    logic [7:0]  y;
    logic [3:0]  lo;
    logic [7:0]  x [4];
    logic [31:0] key;
    logic [2:0]  row;
    bit          active;
    int unsigned n;
    step_out.delete();
    grp_mem[grp_cnt] = b;
    grp_cnt++;
    if (grp_cnt >= GROUP_N || l) begin
      n = grp_cnt;
      g = grp_mem;
      // half swaps only on complete halves, pair swaps only on complete pairs
      if (n >= 5) begin
        t = g[0]; g[0] = g[4]; g[4] = t;
      end
      if (n >= 10) begin
        t = g[5]; g[5] = g[9]; g[9] = t;
      end
      for (int p = 1; p < n; p += 2) begin
        t = g[p-1]; g[p-1] = g[p]; g[p] = t;
      end
      for (int p = 0; p < n; p++) begin
        lo = g[p][3:0] - 4'd7;
        y  = {lo, g[p][7:4]};
        // second pass: word assembly inside the packet window
        active = (pkt_idx >= win_first) && (pkt_idx <= win_last);
        wrd_mem[wrd_cnt] = y;
        wrd_cnt++;
        pkt_off++;
        if (wrd_cnt == 4) begin
          if (active) begin
            key = WORD_XOR[((pkt_off - 4) / 4) % KEY_N];
            row = pkt_idx[2:0];
            for (int k = 0; k < 4; k++) begin
              x[k] = wrd_mem[k] ^ key[8*k +: 8];
            end
            for (int k = 0; k < 4; k++) begin
              queue_byte(x[LANE_SEL[row][k]]);
            end
            wrd_cnt = 0;
          end else begin
            flush_word();
          end
        end
        if (pkt_off >= PKT_BYTES) begin
          flush_word();
          pkt_off = 0;
          if (pkt_idx != 16'hffff) begin
            pkt_idx++;
          end
        end
      end
      grp_cnt = 0;
    end
    // end of stream: flush, mark the final byte, restart the stream state
    if (l) begin
      flush_word();
      step_out[step_out.size()-1].last = 1'b1;
      grp_cnt = 0;
      wrd_cnt = 0;
      pkt_off = 0;
      pkt_idx = '0;
    end
  endtask

  // offer one byte, wait for the transaction, record what it owes
  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input logic [7:0] want);
    fbd_item_t item;
    while (!tx_quiet && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    descramble_step(b, l);
    if (typed) begin
      step_out.delete();
      item.data = want;
      item.last = l;
      step_out.push_back(item);
    end
    foreach (step_out[i]) begin
      plain_bytes_q.push_back(step_out[i]);
    end
  endtask

  // one random stream; long streams get a quiet stretch, and pause_at sets a mid-stream pause
  task automatic send_stream(input int unsigned len, input int pause_at);
    for (int i = 0; i < len; i++) begin
      tx_quiet = (len > 100) && (i >= 10) && (i < 80);
      if (i == pause_at) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (plain_bytes_q.size() != 0) begin
          @(posedge clk);
        end
      end
      send_byte(8'($urandom_range(255)), (i == len - 1), 1'b0, 8'h00);
    end
    tx_quiet = 1'b0;
  endtask

  // stop offering, wait for every owed byte, then let the pipeline go quiet
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (plain_bytes_q.size() != 0 && waited < MAX_WAIT) begin
      @(posedge clk);
      waited++;
    end
    if (plain_bytes_q.size() != 0) begin
      note_mismatch($sformatf("%0d expected bytes never arrived", plain_bytes_q.size()));
      plain_bytes_q.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FIRST: win_first = val;
      REG_LAST:  win_last  = val;
      default: ;
    endcase
  endtask

  // output side: check each transaction, then pick next ready
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk) begin
    fbd_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (plain_bytes_q.size() == 0) begin
        note_mismatch($sformatf("unexpected output byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        want = plain_bytes_q.pop_front();
        if (out_tdata !== want.data) begin
          note_mismatch($sformatf("byte %0d: got %02h want %02h", results_seen, out_tdata,
                                  want.data));
        end
        if (out_tlast !== want.last) begin
          note_mismatch($sformatf("byte %0d: last got %0b want %0b", results_seen, out_tlast,
                                  want.last));
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 50) begin
      // long back-pressure while the sender keeps offering
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (results_seen >= 150 && results_seen < 250) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 16);
    end
  end

  // main sequence
  initial begin
    int unsigned len;
    win_first = FIRST_RESET;
    win_last  = LAST_RESET;
    grp_cnt   = 0;
    wrd_cnt   = 0;
    pkt_off   = 0;
    pkt_idx   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under the reset window
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].want);
    end
    settle();

    // widest window; spare indexes would close it if they aliased
    write_reg(REG_FIRST, 16'h0000);
    write_reg(REG_LAST, 16'hffff);
    write_reg(REG_SPARE_A, 16'hffff);
    write_reg(REG_SPARE_B, 16'h0000);
    // cross two packet ends, end on a partial packet and word
    send_stream(2 * PKT_BYTES + 7, 90);
    settle();

    // small random window
    write_reg(REG_FIRST, 16'($urandom_range(0, 2)));
    write_reg(REG_LAST, 16'($urandom_range(1, 4)));
    len = $urandom_range(30, 60);
    send_stream(len, -1);
    send_stream($urandom_range(1, 20), -1);
    settle();

    // bounds reversed: no packet is keyed or permuted
    write_reg(REG_FIRST, 16'd3);
    write_reg(REG_LAST, 16'd1);
    send_stream(20, -1);
    settle();

    // only packet zero, mostly short streams
    write_reg(REG_FIRST, 16'h0000);
    write_reg(REG_LAST, 16'h0000);
    send_stream(60, -1);
    for (int s = 0; s < 5; s++) begin
      send_stream($urandom_range(1, 12), -1);
    end
    settle();

    // window at the top of the range, never reached
    write_reg(REG_FIRST, 16'hffff);
    write_reg(REG_LAST, 16'hffff);
    send_stream(20, -1);
    settle();

    if (error_count == 0) begin
      $display("[firmware_byte_descrambler] OK");
    end else begin
      $display("[firmware_byte_descrambler] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[firmware_byte_descrambler] ERROR");
    $finish;
  end

endmodule
